/* hw/rtl/shg_pkg.sv */
// shared types, widths and codes for the grid broadphase block
`timescale 1ns / 1ps
`default_nettype none
package shg_pkg;
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int MAX_CELLS_DEF   = 256;
	localparam int CELL_DEPTH_DEF  = 16;

	localparam int COORD_W    = 16;
	localparam int EXT_W      = 17;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int DIM_W      = 5;
	localparam int IDX_W      = 6;
	localparam int STAT_W     = 2;
	localparam int CC_W       = 4;
	localparam int CELL_NUM_W = 8;
	localparam int DIV_STEPS  = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd3;

	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FOUND    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NONE     = 2'd2;
	localparam logic [STAT_W-1:0] ST_REJECT   = 2'd3;

	typedef enum logic [2:0] {
		OUT_INSERT,
		OUT_REJECT,
		OUT_MID,
		OUT_LAST,
		OUT_NONE
	} out_kind_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIVGO,
		S_DIV,
		S_CHECK,
		S_REJECT,
		S_FILL_RD,
		S_CELL,
		S_LIST_RD,
		S_LIST_CHK,
		S_FINISH,
		S_INS_DONE
	} state_t;

	typedef struct packed {
		logic      load_in;
		logic      div_start;
		logic      walk_init;
		logic      walk_next;
		logic      clr_step;
		logic      ins_cell;
		logic      fill_take;
		logic      j_next;
		logic      take_cand;
		logic      out_load;
		out_kind_t out_kind;
		logic      fetch_end;
		logic      count_inc;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic clr_done;
		logic reject;
		logic is_fetch;
		logic last_cell;
		logic fill_zero;
		logic j_last;
		logic cand_new;
		logic pend_valid;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

/* hw/rtl/shg_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module shg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/shg_ctrl.sv */
// controller state machine sequencing insert, fetch and the fill clearing pass
`timescale 1ns / 1ps
`default_nettype none
module shg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire shg_pkg::sts_t sts,
	output shg_pkg::cmd_t      cmd
);
	import shg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.out_kind = OUT_NONE;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DIVGO;
				end
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.reject) begin
					state_d = S_REJECT;
				end else begin
					cmd.walk_init = 1'b1;
					state_d = S_FILL_RD;
				end
			end
			S_REJECT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_REJECT;
					state_d = S_IDLE;
				end
			end
			S_FILL_RD: begin
				state_d = S_CELL;
			end
			S_CELL: begin
				if (!sts.is_fetch) begin
					cmd.ins_cell = 1'b1;
					if (sts.last_cell) begin
						state_d = S_INS_DONE;
					end else begin
						cmd.walk_next = 1'b1;
						state_d = S_FILL_RD;
					end
				end else if (sts.fill_zero) begin
					if (sts.last_cell) begin
						state_d = S_FINISH;
					end else begin
						cmd.walk_next = 1'b1;
						state_d = S_FILL_RD;
					end
				end else begin
					cmd.fill_take = 1'b1;
					state_d = S_LIST_RD;
				end
			end
			S_LIST_RD: begin
				state_d = S_LIST_CHK;
			end
			S_LIST_CHK: begin
				// a new candidate pushes the held one out first
				if (!(sts.cand_new && sts.pend_valid && !sts.out_free)) begin
					if (sts.cand_new) begin
						cmd.take_cand = 1'b1;
						if (sts.pend_valid) begin
							cmd.out_load = 1'b1;
							cmd.out_kind = OUT_MID;
						end
					end
					if (!sts.j_last) begin
						cmd.j_next = 1'b1;
						state_d = S_LIST_RD;
					end else if (sts.last_cell) begin
						state_d = S_FINISH;
					end else begin
						cmd.walk_next = 1'b1;
						state_d = S_FILL_RD;
					end
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = sts.pend_valid ? OUT_LAST : OUT_NONE;
					cmd.fetch_end = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_INS_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_INSERT;
					cmd.count_inc = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end
endmodule
`default_nettype wire

/* hw/rtl/shg_dp.sv */
// datapath: config registers, cell divider, cell walk, cell memories, result register
`timescale 1ns / 1ps
`default_nettype none
module shg_dp #(
	parameter int MAX_ENTRIES = shg_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_CELLS   = shg_pkg::MAX_CELLS_DEF,
	parameter int CELL_DEPTH  = shg_pkg::CELL_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [shg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [shg_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            action,
	input  wire logic [shg_pkg::COORD_W-1:0]     rect_x,
	input  wire logic [shg_pkg::COORD_W-1:0]     rect_y,
	input  wire logic [shg_pkg::COORD_W-1:0]     rect_w,
	input  wire logic [shg_pkg::COORD_W-1:0]     rect_h,
	input  wire shg_pkg::cmd_t                   cmd,
	output shg_pkg::sts_t                        sts,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic      [shg_pkg::IDX_W-1:0]       entry_index,
	output logic      [shg_pkg::STAT_W-1:0]      status,
	output logic                                 cell_overflow,
	output logic                                 last
);
	import shg_pkg::*;

	localparam int EW     = $clog2(MAX_ENTRIES);
	localparam int CNTW   = $clog2(MAX_ENTRIES + 1);
	localparam int CAW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int FW     = $clog2(CELL_DEPTH + 1);
	localparam int LDEPTH = MAX_CELLS * CELL_DEPTH;
	localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;

	// configuration
	logic [CFG_W-1:0] cw_q, ch_q;
	logic [DIM_W-1:0] cols_q, rows_q;
	logic [CFG_W-1:0] cw_eff, ch_eff;
	logic [DIM_W-1:0] cols_eff, rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q   <= 16'd16;
			ch_q   <= 16'd16;
			cols_q <= 5'd16;
			rows_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELL_WIDTH:   cw_q   <= cfg_data;
				CFG_CELL_HEIGHT:  ch_q   <= cfg_data;
				CFG_GRID_COLUMNS: cols_q <= cfg_data[DIM_W-1:0];
				CFG_GRID_ROWS:    rows_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cw_eff   = (cw_q == '0) ? 16'd1 : cw_q;
	assign ch_eff   = (ch_q == '0) ? 16'd1 : ch_q;
	assign cols_eff = (cols_q == '0) ? 5'd1 : ((cols_q > 5'd16) ? 5'd16 : cols_q);
	assign rows_eff = (rows_q == '0) ? 5'd1 : ((rows_q > 5'd16) ? 5'd16 : rows_q);

	// item registers
	logic             act_q;
	logic [EXT_W-1:0] x_q, y_q, xe_q, ye_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= action;
			x_q   <= {1'b0, rect_x};
			y_q   <= {1'b0, rect_y};
			xe_q  <= {1'b0, rect_x} + {1'b0, rect_w};
			ye_q  <= {1'b0, rect_y} + {1'b0, rect_h};
		end
	end

	// shared restoring divider, one quotient bit per cycle, four quotients in turn
	logic             div_busy_q;
	logic [1:0]       div_k_q, div_ksel;
	logic [4:0]       div_bit_q;
	logic [EXT_W-1:0] div_quo_q, div_quo_next, div_op;
	logic [CFG_W-1:0] div_rem_q, div_rem_next, div_dvs;
	logic [EXT_W-1:0] div_t;
	logic             div_ge;
	logic [EXT_W-1:0] qx0_q, qy0_q, qx1_q, qy1_q;

	assign div_ksel = cmd.div_start ? 2'd0 : div_k_q + 2'd1;

	always_comb begin
		case (div_ksel)
			2'd0:    div_op = x_q;
			2'd1:    div_op = y_q;
			2'd2:    div_op = xe_q;
			default: div_op = ye_q;
		endcase
	end

	assign div_dvs      = div_k_q[0] ? ch_eff : cw_eff;
	assign div_t        = {div_rem_q, div_quo_q[EXT_W-1]};
	assign div_ge       = div_t >= {1'b0, div_dvs};
	assign div_rem_next = div_ge ? CFG_W'(div_t - {1'b0, div_dvs}) : div_t[CFG_W-1:0];
	assign div_quo_next = {div_quo_q[EXT_W-2:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_k_q    <= '0;
			div_bit_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_k_q    <= '0;
			div_bit_q  <= '0;
		end else if (div_busy_q) begin
			if (div_bit_q == 5'(DIV_STEPS - 1)) begin
				div_bit_q <= '0;
				if (div_k_q == 2'd3) begin
					div_busy_q <= 1'b0;
				end else begin
					div_k_q <= div_k_q + 2'd1;
				end
			end else begin
				div_bit_q <= div_bit_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_quo_q <= div_op;
			div_rem_q <= '0;
		end else if (div_busy_q) begin
			if (div_bit_q == 5'(DIV_STEPS - 1)) begin
				case (div_k_q)
					2'd0:    qx0_q <= div_quo_next;
					2'd1:    qy0_q <= div_quo_next;
					2'd2:    qx1_q <= div_quo_next;
					default: qy1_q <= div_quo_next;
				endcase
				div_quo_q <= div_op;
				div_rem_q <= '0;
			end else begin
				div_quo_q <= div_quo_next;
				div_rem_q <= div_rem_next;
			end
		end
	end

	// range check on the far corner cell and on the table
	logic [CNTW-1:0]       count_q;
	logic [CELL_NUM_W-1:0] far_cell;
	logic                  grid_bad, cells_bad, table_full;

	assign grid_bad   = (qx1_q >= EXT_W'(cols_eff)) || (qy1_q >= EXT_W'(rows_eff));
	assign far_cell   = CELL_NUM_W'({4'b0, qy1_q[CC_W-1:0]} * {3'b0, cols_eff})
		+ {4'b0, qx1_q[CC_W-1:0]};
	assign cells_bad  = int'(far_cell) >= MAX_CELLS;
	assign table_full = !act_q && (count_q >= CNTW'(MAX_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_inc) begin
			count_q <= count_q + 1'b1;
		end
	end

	// cell walk
	logic [CC_W-1:0]       cx_q, cy_q;
	logic                  ovf_q;
	logic [CELL_NUM_W-1:0] cell_num;
	logic [CAW-1:0]        cell_addr;
	logic                  fill_full;

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			cx_q  <= qx0_q[CC_W-1:0];
			cy_q  <= qy0_q[CC_W-1:0];
			ovf_q <= 1'b0;
		end else if (cmd.walk_next) begin
			if (cx_q == qx1_q[CC_W-1:0]) begin
				cx_q <= qx0_q[CC_W-1:0];
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
		if (cmd.ins_cell && fill_full) begin
			ovf_q <= 1'b1;
		end
	end

	assign cell_num  = CELL_NUM_W'({4'b0, cy_q} * {3'b0, cols_eff}) + {4'b0, cx_q};
	assign cell_addr = CAW'(cell_num);

	// fill count memory, swept to zero after reset
	logic [CAW-1:0] clr_q;
	logic           fill_we;
	logic [CAW-1:0] fill_waddr;
	logic [FW-1:0]  fill_wdata, fill_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign fill_full  = fill_rd >= FW'(CELL_DEPTH);
	assign fill_we    = cmd.clr_step || (cmd.ins_cell && !fill_full);
	assign fill_waddr = cmd.clr_step ? clr_q : cell_addr;
	assign fill_wdata = cmd.clr_step ? '0 : fill_rd + 1'b1;

	shg_ram #(.WIDTH(FW), .DEPTH(MAX_CELLS)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (cell_addr),
		.rdata (fill_rd)
	);

	// cell list memory
	logic [FW-1:0]    fill_n_q, j_q;
	logic             list_we;
	logic [LAW-1:0]   list_waddr, list_raddr;
	logic [IDX_W-1:0] list_rd;

	always_ff @(posedge clk) begin
		if (cmd.fill_take) begin
			fill_n_q <= fill_full ? FW'(CELL_DEPTH) : fill_rd;
			j_q      <= '0;
		end else if (cmd.j_next) begin
			j_q <= j_q + 1'b1;
		end
	end

	assign list_we    = cmd.ins_cell && !fill_full;
	assign list_waddr = LAW'(int'(cell_num) * CELL_DEPTH + int'(fill_rd));
	assign list_raddr = LAW'(int'(cell_num) * CELL_DEPTH + int'(j_q));

	shg_ram #(.WIDTH(IDX_W), .DEPTH(LDEPTH)) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (IDX_W'(count_q)),
		.raddr (list_raddr),
		.rdata (list_rd)
	);

	// found flags and the held candidate
	logic [MAX_ENTRIES-1:0] flags_q;
	logic [EW-1:0]          flag_idx;
	logic                   e_ok;
	logic [IDX_W-1:0]       pend_q;
	logic                   pend_valid_q;

	assign e_ok     = int'(list_rd) < MAX_ENTRIES;
	assign flag_idx = EW'(list_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.fetch_end) begin
			flags_q      <= '0;
			pend_valid_q <= 1'b0;
		end else if (cmd.take_cand) begin
			flags_q[flag_idx] <= 1'b1;
			pend_valid_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_cand) begin
			pend_q <= list_rd;
		end
	end

	// result register
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic [STAT_W-1:0] stat_q;
	logic             ovf_out_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				OUT_INSERT: begin
					idx_q     <= IDX_W'(count_q);
					stat_q    <= ST_INSERTED;
					ovf_out_q <= ovf_q;
					last_q    <= 1'b1;
				end
				OUT_MID: begin
					idx_q     <= pend_q;
					stat_q    <= ST_FOUND;
					ovf_out_q <= 1'b0;
					last_q    <= 1'b0;
				end
				OUT_LAST: begin
					idx_q     <= pend_q;
					stat_q    <= ST_FOUND;
					ovf_out_q <= 1'b0;
					last_q    <= 1'b1;
				end
				OUT_NONE: begin
					idx_q     <= '0;
					stat_q    <= ST_NONE;
					ovf_out_q <= 1'b0;
					last_q    <= 1'b1;
				end
				default: begin
					idx_q     <= '0;
					stat_q    <= ST_REJECT;
					ovf_out_q <= 1'b0;
					last_q    <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign entry_index   = idx_q;
	assign status        = stat_q;
	assign cell_overflow = ovf_out_q;
	assign last          = last_q;

	always_comb begin
		sts.div_busy   = div_busy_q;
		sts.clr_done   = clr_q == CAW'(MAX_CELLS - 1);
		sts.reject     = grid_bad || cells_bad || table_full;
		sts.is_fetch   = act_q;
		sts.last_cell  = (cx_q == qx1_q[CC_W-1:0]) && (cy_q == qy1_q[CC_W-1:0]);
		sts.fill_zero  = fill_rd == '0;
		sts.j_last     = ({1'b0, j_q} + 1'b1) >= {1'b0, fill_n_q};
		sts.cand_new   = e_ok && !flags_q[flag_idx];
		sts.pend_valid = pend_valid_q;
		sts.out_free   = !out_valid_q || !out_stall;
	end
endmodule
`default_nettype wire

/* hw/rtl/spatial_hash_grid_broadphase.sv */
// top level of the uniform grid broadphase: controller plus datapath
// Input channel (in_valid/in_stall) takes one rectangle with an action: insert
// gives it the next entry index and appends it to every covered cell that has
// room, fetch returns each distinct index stored in the covered cells once, in order met.
// Output channel (out_valid/out_stall) gives one result per insert or reject,
// and one per candidate (or a single no-candidate result) per fetch; last
// marks the final result of an item. Config is a plain write port, used idle.
// Work per item: four quotients from the shared divider, then a walk over the
// covered cells, plus a read of each stored index on fetch.
// One item is in work at a time; the next transfer is taken once the last
// result of the current item is in the output register.
// After reset the fill count memory is swept to zero with in_stall high;
// config writes are taken during the sweep.
// A stalled receiver holds the output register; a fetch walk waits only when a new candidate finds it full.
`timescale 1ns / 1ps
`default_nettype none
module spatial_hash_grid_broadphase #(
	parameter int MAX_ENTRIES = shg_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_CELLS   = shg_pkg::MAX_CELLS_DEF,
	parameter int CELL_DEPTH  = shg_pkg::CELL_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [shg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [shg_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          action,
	input  wire logic [shg_pkg::COORD_W-1:0]   rect_x,
	input  wire logic [shg_pkg::COORD_W-1:0]   rect_y,
	input  wire logic [shg_pkg::COORD_W-1:0]   rect_w,
	input  wire logic [shg_pkg::COORD_W-1:0]   rect_h,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [shg_pkg::IDX_W-1:0]     entry_index,
	output logic      [shg_pkg::STAT_W-1:0]    status,
	output logic                               cell_overflow,
	output logic                               last
);
	import shg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	shg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	shg_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_CELLS   (MAX_CELLS),
		.CELL_DEPTH  (CELL_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.rect_x        (rect_x),
		.rect_y        (rect_y),
		.rect_w        (rect_w),
		.rect_h        (rect_h),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.entry_index   (entry_index),
		.status        (status),
		.cell_overflow (cell_overflow),
		.last          (last)
	);

	// one item at a time: a transfer closes the input until the item is done
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in work");

	// the result register is never overwritten while it still holds a result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register loaded while full");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_REJECT) |-> (entry_index == '0 && last && !cell_overflow))
		else $error("malformed reject result");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NONE) |-> last)
		else $error("no-candidate result not marked last");
endmodule
`default_nettype wire

/* tb/tb_spatial_hash_grid_broadphase.sv */
// testbench for spatial_hash_grid_broadphase: directed table, random rectangles, own predictor
`timescale 1ns / 1ps
module tb_spatial_hash_grid_broadphase;
	import shg_pkg::*;

	localparam int N_ENTRIES  = MAX_ENTRIES_DEF;
	localparam int N_CELLS    = MAX_CELLS_DEF;
	localparam int DEPTH      = CELL_DEPTH_DEF;
	localparam int STALL_LIMIT = 60000;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [STAT_W-1:0] stat;
		logic              ovf;
		logic              fin;
	} grid_result_t;

	typedef struct {
		logic                act;
		logic [COORD_W-1:0]  x, y, w, h;
		int                  reps;
		bit                  typed;
		grid_result_t        res;
	} rect_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CELL_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [COORD_W-1:0] rect_x = '0, rect_y = '0, rect_w = '0, rect_h = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [IDX_W-1:0] entry_index;
	logic [STAT_W-1:0] status;
	logic cell_overflow;
	logic last;

	spatial_hash_grid_broadphase u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
		.out_valid(out_valid), .out_stall(out_stall),
		.entry_index(entry_index), .status(status),
		.cell_overflow(cell_overflow), .last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// grid model
	int unsigned cell_w_reg = 16, cell_h_reg = 16, cols_reg = 16, rows_reg = 16;
	int unsigned entry_total = 0;
	int unsigned fill_model[N_CELLS];
	logic [IDX_W-1:0] list_model[N_CELLS][DEPTH];
	grid_result_t pending_results[$];

	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int rejects_seen = 0;
	int overflows_seen = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;
	bit hold_used = 1'b0;
	int quiet_cycles = 0;

	function automatic int unsigned eff_dim(int unsigned v);
		if (v == 0) return 1;
		if (v > 16) return 16;
		return v;
	endfunction

	function automatic void push_result(logic [IDX_W-1:0] idx, logic [STAT_W-1:0] st,
			logic ovf, logic fin);
		grid_result_t r;
		r.idx = idx; r.stat = st; r.ovf = ovf; r.fin = fin;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_rect(logic act, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
		int unsigned cw, ch, cols, rows, cx0, cy0, cx1, cy1, c, n, fill;
		logic ovf;
		logic [IDX_W-1:0] idx;
		bit seen[N_ENTRIES];
		cw = cell_w_reg ? cell_w_reg : 1;
		ch = cell_h_reg ? cell_h_reg : 1;
		cols = eff_dim(cols_reg);
		rows = eff_dim(rows_reg);
		cx0 = x / cw; cy0 = y / ch;
		cx1 = (int'(x) + int'(w)) / cw;
		cy1 = (int'(y) + int'(h)) / ch;
		n = 0;
		ovf = 1'b0;
		if (cx1 >= cols || cy1 >= rows || cy1 * cols + cx1 >= N_CELLS ||
				(act == 1'b0 && entry_total >= N_ENTRIES)) begin
			push_result('0, ST_REJECT, 1'b0, 1'b1);
			return;
		end
		if (act == 1'b0) begin
			idx = entry_total[IDX_W-1:0];
			entry_total++;
			for (int unsigned cy = cy0; cy <= cy1; cy++)
				for (int unsigned cx = cx0; cx <= cx1; cx++) begin
					c = cy * cols + cx;
					if (fill_model[c] >= DEPTH) begin
						ovf = 1'b1;
					end else begin
						list_model[c][fill_model[c]] = idx;
						fill_model[c]++;
					end
				end
			push_result(idx, ST_INSERTED, ovf, 1'b1);
			return;
		end
		for (int unsigned cy = cy0; cy <= cy1; cy++)
			for (int unsigned cx = cx0; cx <= cx1; cx++) begin
				c = cy * cols + cx;
				fill = fill_model[c];
				for (int j = 0; j < fill; j++) begin
					idx = list_model[c][j];
					if (!seen[idx]) begin
						seen[idx] = 1'b1;
						push_result(idx, ST_FOUND, 1'b0, 1'b0);
						n++;
					end
				end
			end
		if (n == 0)
			push_result('0, ST_NONE, 1'b0, 1'b1);
		else
			pending_results[$].fin = 1'b1;
	endfunction

	// output side: checking, random stall and the long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				grid_result_t e;
				results_seen++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result idx=%0d status=%0d ovf=%0b last=%0b",
						$time, entry_index, status, cell_overflow, last);
				end else begin
					e = pending_results.pop_front();
					if (status == ST_REJECT) rejects_seen++;
					if (cell_overflow) overflows_seen++;
					if (entry_index !== e.idx || status !== e.stat ||
							cell_overflow !== e.ovf || last !== e.fin) begin
						errors++;
						$display("%0t: mismatch expected idx=%0d status=%0d ovf=%0b last=%0b",
							$time, e.idx, e.stat, e.ovf, e.fin);
						$display("%0t:          actual   idx=%0d status=%0d ovf=%0b last=%0b",
							$time, entry_index, status, cell_overflow, last);
					end
				end
			end
			if (hold_req && !hold_used) begin
				hold_used <= 1'b1;
				hold_left <= 400;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 37);
			end
		end
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_rect(logic act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
		if (idle_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		rect_x <= x; rect_y <= y; rect_w <= w; rect_h <= h;
		do @(posedge clk); while (in_stall);
		predict_rect(act, x, y, w, h);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_layout(int unsigned cw, int unsigned ch, int unsigned cols,
			int unsigned rows);
		logic [CFG_IDX_W-1:0] regs[4];
		logic [CFG_W-1:0] vals[4];
		regs = '{CFG_CELL_WIDTH, CFG_CELL_HEIGHT, CFG_GRID_COLUMNS, CFG_GRID_ROWS};
		vals = '{cw[CFG_W-1:0], ch[CFG_W-1:0], cols[CFG_W-1:0], rows[CFG_W-1:0]};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cell_w_reg = cw & 16'hFFFF;
		cell_h_reg = ch & 16'hFFFF;
		cols_reg = cols & 5'h1F;
		rows_reg = rows & 5'h1F;
	endtask

	task automatic random_rects(int count);
		int unsigned cw, ch;
		longint span_x, span_y;
		logic [COORD_W-1:0] x, y, w, h;
		cw = cell_w_reg ? cell_w_reg : 1;
		ch = cell_h_reg ? cell_h_reg : 1;
		span_x = longint'(cw) * eff_dim(cols_reg);
		span_y = longint'(ch) * eff_dim(rows_reg);
		if (span_x > 65536) span_x = 65536;
		if (span_y > 65536) span_y = 65536;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 15) begin
				x = COORD_W'($urandom);
				y = COORD_W'($urandom);
				w = COORD_W'($urandom);
				h = COORD_W'($urandom);
			end else begin
				x = COORD_W'($urandom_range(0, int'(span_x) - 1));
				y = COORD_W'($urandom_range(0, int'(span_y) - 1));
				w = COORD_W'($urandom_range(0, cw * 2 > 65535 ? 65535 : cw * 2));
				h = COORD_W'($urandom_range(0, ch * 2 > 65535 ? 65535 : ch * 2));
			end
			send_rect(1'($urandom_range(1)), x, y, w, h);
		end
	endtask

	rect_row_t plan[] = '{
		'{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1, 1'b1, '{6'd0, ST_NONE, 1'b0, 1'b1}},
		'{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1, 1'b1, '{6'd0, ST_INSERTED, 1'b0, 1'b1}},
		'{1'b0, 16'd255, 16'd255, 16'd0, 16'd0, 1, 1'b1, '{6'd1, ST_INSERTED, 1'b0, 1'b1}},
		'{1'b0, 16'd256, 16'd0, 16'd0, 16'd0, 1, 1'b1, '{6'd0, ST_REJECT, 1'b0, 1'b1}},
		'{1'b1, 16'd0, 16'd256, 16'd0, 16'd0, 1, 1'b1, '{6'd0, ST_REJECT, 1'b0, 1'b1}},
		'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b1,
			'{6'd0, ST_REJECT, 1'b0, 1'b1}},
		'{1'b1, 16'd0, 16'd0, 16'd255, 16'd255, 1, 1'b0, '{6'd0, ST_NONE, 1'b0, 1'b0}},
		'{1'b0, 16'd0, 16'd0, 16'd255, 16'd255, 1, 1'b0, '{6'd0, ST_NONE, 1'b0, 1'b0}},
		'{1'b1, 16'd0, 16'd0, 16'd15, 16'd15, 1, 1'b0, '{6'd0, ST_NONE, 1'b0, 1'b0}},
		'{1'b1, 16'd240, 16'd0, 16'd15, 16'd255, 1, 1'b0, '{6'd0, ST_NONE, 1'b0, 1'b0}},
		// fill the corner cell to depth, then one more insert overflows it
		'{1'b0, 16'd3, 16'd7, 16'd0, 16'd0, 15, 1'b0, '{6'd0, ST_NONE, 1'b0, 1'b0}},
		'{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1, 1'b0, '{6'd0, ST_NONE, 1'b0, 1'b0}}
	};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r])
			for (int k = 0; k < plan[r].reps; k++) begin
				send_rect(plan[r].act, plan[r].x, plan[r].y, plan[r].w, plan[r].h);
				// typed rows replace the predicted value with the one typed into the table
				if (plan[r].typed) pending_results[$] = plan[r].res;
			end
		drain();

		random_rects(60);
		drain();

		set_layout(1, 1, 16, 16);
		idle_on = 1'b0;
		random_rects(60);
		drain();
		idle_on = 1'b1;

		set_layout(65535, 65535, 1, 1);
		hold_req = 1'b1;
		random_rects(60);
		drain();

		set_layout(0, 0, 0, 0);
		random_rects(50);
		drain();

		set_layout(4, 8, 31, 31);
		random_rects(87);
		drain();

		set_layout(100, 50, 5, 3);
		random_rects(87);
		drain();

		repeat (50) @(posedge clk);
		$display("run covered %0d rectangles over six grid layouts, %0d results checked",
			items_sent, results_seen);
		$display("rejected %0d, cell overflow seen %0d times, errors %0d",
			rejects_seen, overflows_seen, errors);
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
